FILE: design/rgbds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbds_pkg
// Shared constants, widths and types for the RGB image difference statistics
// core: lane results, pixel control and the end-of-image snapshot.
// ----------------------------------------------------------------------------
package rgbds_pkg;

  // Build-time sizing.
  localparam int MAX_PIXELS_LOG2 = 22;
  localparam int SAMPLE_BITS     = 16;

  // Fixed port widths.
  localparam int FIELD_W   = 16;
  localparam int OUTLIER_W = 23;

  // One lane per color channel.
  localparam int CHANNELS = 3;

  // Derived widths.
  localparam int DIFF_W  = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
  localparam int SQR_W   = 2 * DIFF_W;
  localparam int TALLY_W = MAX_PIXELS_LOG2 + 1;
  localparam int ABS_W   = DIFF_W + MAX_PIXELS_LOG2 + 2;
  localparam int SQ_W    = SQR_W + MAX_PIXELS_LOG2 + 2;
  localparam int DEN_W   = TALLY_W + 2;

  // Result of one channel lane.
  typedef struct packed {
    logic [DIFF_W-1:0] diff;
    logic [SQR_W-1:0]  sq;
  } lane_res_t;

  // Control that travels with a pixel beside the lane results.
  typedef struct packed {
    logic               valid;
    logic               keep;
    logic               last;
    logic [TALLY_W-1:0] tally;
  } pix_ctrl_t;

  // Totals of one image, handed on when its last pixel has been merged.
  typedef struct packed {
    logic               valid;
    logic [ABS_W-1:0]   abs_sum;
    logic [SQ_W-1:0]    sq_sum;
    logic [DIFF_W-1:0]  max_diff;
    logic [TALLY_W-1:0] outliers;
    logic [DEN_W-1:0]   den;
  } snap_t;

endpackage

FILE: design/rgb_image_diff_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_image_diff_statistics_core
// Mean absolute error, RMS error, maximum error and outlier count of two RGB
// images in unsigned Q4.12, one pixel pair per word.
//
//   port group   direction  handshake            contents
//   in_*         input      in_valid / in_stall  A and B channels, last flag
//   out_*        output     out_valid/out_stall  mean, rms, max, outliers
//   cfg_*        input      cfg_wr_en            outlier threshold
//
// Pixels that are not the last of an image are taken one per cycle; three
// channel lanes and the merging stage keep pace with that.
// The last pixel holds the input until the image's result is loaded, after
// the bit-serial divider has run twice and the bit-serial square root has
// run; a stalled result register delays that load.
// Reset is synchronous, active low, and clears all totals and the threshold.
// A stalled result does not block the next image until its last pixel.
// ----------------------------------------------------------------------------
module rgb_image_diff_statistics_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration
  input  logic                            cfg_wr_en,
  input  logic [rgbds_pkg::FIELD_W-1:0]   cfg_wr_data,
  // Input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rgbds_pkg::FIELD_W-1:0]   in_a_red,
  input  logic [rgbds_pkg::FIELD_W-1:0]   in_a_green,
  input  logic [rgbds_pkg::FIELD_W-1:0]   in_a_blue,
  input  logic [rgbds_pkg::FIELD_W-1:0]   in_b_red,
  input  logic [rgbds_pkg::FIELD_W-1:0]   in_b_green,
  input  logic [rgbds_pkg::FIELD_W-1:0]   in_b_blue,
  input  logic                            in_final_pixel,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rgbds_pkg::FIELD_W-1:0]   out_mean_abs_error,
  output logic [rgbds_pkg::FIELD_W-1:0]   out_rms_error,
  output logic [rgbds_pkg::FIELD_W-1:0]   out_max_abs_error,
  output logic [rgbds_pkg::OUTLIER_W-1:0] out_outlier_pixels
);
  import rgbds_pkg::*;

  localparam logic [TALLY_W-1:0] PIXEL_CAP = TALLY_W'(1) << MAX_PIXELS_LOG2;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_DIV_ABS,
    ST_DIV_SQ,
    ST_ROOT,
    ST_OUT
  } state_t;

  state_t             state_r;
  logic               busy_r;
  logic [FIELD_W-1:0] thr_r;
  logic [TALLY_W-1:0] tally_r;
  pix_ctrl_t          s1_ctrl_r;

  logic               accept;
  logic               keep;
  logic [TALLY_W-1:0] tally_after;

  logic [FIELD_W-1:0] a_ch [CHANNELS];
  logic [FIELD_W-1:0] b_ch [CHANNELS];
  lane_res_t          lane_res [CHANNELS];
  snap_t              snap;

  // End-of-image holding registers.
  logic [SQ_W-1:0]    sq_hold_r;
  logic [DEN_W-1:0]   den_r;
  logic [DIFF_W-1:0]  max_hold_r;
  logic [TALLY_W-1:0] outl_hold_r;
  logic [DIFF_W-1:0]  mean_r;
  logic               den_zero;

  // Shared divider and root unit.
  logic               div_start;
  logic [SQ_W-1:0]    div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_busy;
  logic               div_done;
  logic [SQ_W-1:0]    div_q;
  logic               sqrt_start;
  logic [SQR_W-1:0]   sqrt_rad;
  logic               sqrt_busy;
  logic               sqrt_done;
  logic [DIFF_W-1:0]  sqrt_root;

  // Result register.
  logic                 out_valid_r;
  logic [FIELD_W-1:0]   out_mean_r;
  logic [FIELD_W-1:0]   out_rms_r;
  logic [FIELD_W-1:0]   out_max_r;
  logic [OUTLIER_W-1:0] out_outl_r;
  logic                 out_free;

  // Input handshake and pixel counting ahead of the lanes.
  assign in_stall    = busy_r;
  assign accept      = in_valid && !busy_r;
  assign keep        = tally_r < PIXEL_CAP;
  assign tally_after = keep ? (tally_r + TALLY_W'(1)) : tally_r;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Pixel tally and control beside the lane stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r   <= '0;
      s1_ctrl_r <= '0;
    end else begin
      s1_ctrl_r.valid <= accept;
      s1_ctrl_r.keep  <= accept && keep;
      s1_ctrl_r.last  <= in_final_pixel;
      s1_ctrl_r.tally <= tally_after;
      if (accept) begin
        tally_r <= in_final_pixel ? '0 : tally_after;
      end
    end
  end

  // Channel lanes.
  assign a_ch[0] = in_a_red;
  assign a_ch[1] = in_a_green;
  assign a_ch[2] = in_a_blue;
  assign b_ch[0] = in_b_red;
  assign b_ch[1] = in_b_green;
  assign b_ch[2] = in_b_blue;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    rgbds_lane u_lane (
      .clk  (clk),
      .a_ch (a_ch[g]),
      .b_ch (b_ch[g]),
      .res  (lane_res[g])
    );
  end

  rgbds_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane      (lane_res),
    .ctrl      (s1_ctrl_r),
    .threshold (thr_r),
    .snap      (snap)
  );

  // Operand selection for the shared divider and the root unit.
  always_comb begin
    div_start  = ((state_r == ST_ACC) && snap.valid) ||
                 ((state_r == ST_DIV_ABS) && div_done);
    div_num    = (state_r == ST_ACC) ? SQ_W'(snap.abs_sum) : sq_hold_r;
    div_den    = (state_r == ST_ACC) ? snap.den : den_r;
    den_zero   = (den_r == '0);
    sqrt_start = (state_r == ST_DIV_SQ) && div_done;
    sqrt_rad   = den_zero ? '0 : div_q[SQR_W-1:0];
    out_free   = !out_valid_r || !out_stall;
  end

  rgbds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q)
  );

  rgbds_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // End-of-image sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result empties the register unless a new one is loaded below.
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_final_pixel) begin
        busy_r <= 1'b1;
      end
      unique case (state_r)
        ST_ACC: begin
          if (snap.valid) begin
            sq_hold_r   <= snap.sq_sum;
            den_r       <= snap.den;
            max_hold_r  <= snap.max_diff;
            outl_hold_r <= snap.outliers;
            state_r     <= ST_DIV_ABS;
          end
        end
        ST_DIV_ABS: begin
          if (div_done) begin
            mean_r  <= den_zero ? '0 : div_q[DIFF_W-1:0];
            state_r <= ST_DIV_SQ;
          end
        end
        ST_DIV_SQ: begin
          if (div_done) begin
            state_r <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_mean_r  <= FIELD_W'(mean_r);
            out_rms_r   <= FIELD_W'(sqrt_root);
            out_max_r   <= FIELD_W'(max_hold_r);
            out_outl_r  <= OUTLIER_W'(outl_hold_r);
            busy_r      <= 1'b0;
            state_r     <= ST_ACC;
          end
        end
        default: begin
          state_r <= ST_ACC;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mean_abs_error = out_mean_r;
  assign out_rms_error      = out_rms_r;
  assign out_max_abs_error  = out_max_r;
  assign out_outlier_pixels = out_outl_r;

  // The input stays closed while an image is being finished.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ACC) |-> busy_r)
    else $error("input open while image totals are in flight");

  // A snapshot only arrives while the sequencer is waiting for one.
  assert property (@(posedge clk) disable iff (!rst_n)
    snap.valid |-> (state_r == ST_ACC))
    else $error("snapshot arrived while sequencer busy");

  // The shared units are never restarted mid-run.
  assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_busy)
    else $error("root unit started while busy");

  // A new result only appears at the end of an image.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(busy_r) && !busy_r)
    else $error("result loaded outside the end of an image");

endmodule

FILE: design/rgbds_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbds_lane
// One channel lane: absolute difference of two samples and its square,
// both registered.
// ----------------------------------------------------------------------------
module rgbds_lane (
  input  logic                            clk,
  input  logic [rgbds_pkg::FIELD_W-1:0]   a_ch,
  input  logic [rgbds_pkg::FIELD_W-1:0]   b_ch,
  output rgbds_pkg::lane_res_t            res
);
  import rgbds_pkg::*;

  logic [DIFF_W-1:0] a_s;
  logic [DIFF_W-1:0] b_s;
  logic [DIFF_W-1:0] diff_nxt;
  lane_res_t         res_r;

  // Only the low sample bits take part.
  always_comb begin
    a_s      = a_ch[DIFF_W-1:0];
    b_s      = b_ch[DIFF_W-1:0];
    diff_nxt = (a_s >= b_s) ? (a_s - b_s) : (b_s - a_s);
  end

  // Register the difference and its square.
  always_ff @(posedge clk) begin
    res_r.diff <= diff_nxt;
    res_r.sq   <= SQR_W'(diff_nxt) * SQR_W'(diff_nxt);
  end

  assign res = res_r;

endmodule

FILE: design/rgbds_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbds_merge
// Merging stage: combines the three lane results of a pixel and accumulates
// the image totals. On the last pixel it hands on a snapshot and clears.
// ----------------------------------------------------------------------------
module rgbds_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rgbds_pkg::lane_res_t          lane [rgbds_pkg::CHANNELS],
  input  rgbds_pkg::pix_ctrl_t          ctrl,
  input  logic [rgbds_pkg::FIELD_W-1:0] threshold,
  output rgbds_pkg::snap_t              snap
);
  import rgbds_pkg::*;

  logic [ABS_W-1:0]   abs_sum_r;
  logic [SQ_W-1:0]    sq_sum_r;
  logic [DIFF_W-1:0]  max_r;
  logic [TALLY_W-1:0] outl_r;

  logic [ABS_W-1:0]   abs_nxt;
  logic [SQ_W-1:0]    sq_nxt;
  logic [DIFF_W-1:0]  max_nxt;
  logic [TALLY_W-1:0] outl_nxt;

  logic [DIFF_W+1:0]  pix_abs;
  logic [SQR_W+1:0]   pix_sq;
  logic [DIFF_W-1:0]  pix_max;
  logic [DIFF_W-1:0]  thr;
  logic               hit;

  snap_t snap_r;

  // Combine the lanes and form the next totals.
  always_comb begin
    pix_abs = '0;
    pix_sq  = '0;
    pix_max = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      pix_abs = pix_abs + (DIFF_W+2)'(lane[c].diff);
      pix_sq  = pix_sq + (SQR_W+2)'(lane[c].sq);
      if (lane[c].diff > pix_max) begin
        pix_max = lane[c].diff;
      end
    end
    thr = threshold[DIFF_W-1:0];
    hit = (thr != '0) && (pix_max > thr);

    abs_nxt  = abs_sum_r;
    sq_nxt   = sq_sum_r;
    max_nxt  = max_r;
    outl_nxt = outl_r;
    if (ctrl.keep) begin
      abs_nxt = abs_sum_r + ABS_W'(pix_abs);
      sq_nxt  = sq_sum_r + SQ_W'(pix_sq);
      if (pix_max > max_r) begin
        max_nxt = pix_max;
      end
      if (hit) begin
        outl_nxt = outl_r + TALLY_W'(1);
      end
    end
  end

  // Accumulators and the snapshot; the divisor is three samples per counted
  // pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_sum_r    <= '0;
      sq_sum_r     <= '0;
      max_r        <= '0;
      outl_r       <= '0;
      snap_r.valid <= 1'b0;
    end else begin
      snap_r.valid <= ctrl.valid && ctrl.last;
      if (ctrl.valid && ctrl.last) begin
        snap_r.abs_sum  <= abs_nxt;
        snap_r.sq_sum   <= sq_nxt;
        snap_r.max_diff <= max_nxt;
        snap_r.outliers <= outl_nxt;
        snap_r.den      <= DEN_W'(ctrl.tally) * DEN_W'(CHANNELS);
      end
      if (ctrl.valid) begin
        if (ctrl.last) begin
          abs_sum_r <= '0;
          sq_sum_r  <= '0;
          max_r     <= '0;
          outl_r    <= '0;
        end else begin
          abs_sum_r <= abs_nxt;
          sq_sum_r  <= sq_nxt;
          max_r     <= max_nxt;
          outl_r    <= outl_nxt;
        end
      end
    end
  end

  assign snap = snap_r;

endmodule

FILE: design/rgbds_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbds_div
// Restoring divider, one quotient bit per cycle. Shared by the mean and the
// mean-square divisions.
// ----------------------------------------------------------------------------
module rgbds_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [rgbds_pkg::SQ_W-1:0]   num,
  input  logic [rgbds_pkg::DEN_W-1:0]  den,
  output logic                         busy,
  output logic                         done,
  output logic [rgbds_pkg::SQ_W-1:0]   quot
);
  import rgbds_pkg::*;

  localparam int CNT_W = $clog2(SQ_W + 1);

  logic [SQ_W-1:0]  num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh = {rem_r, num_r[SQ_W-1]};
    fits   = rem_sh >= {1'b0, den_r};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(SQ_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Dividend register shifts out numerator bits and takes in quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      num_r <= {num_r[SQ_W-2:0], fits};
      rem_r <= fits ? DEN_W'(rem_sh - {1'b0, den_r}) : DEN_W'(rem_sh);
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quot = num_r;

endmodule

FILE: design/rgbds_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbds_sqrt
// Digit-by-digit floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rgbds_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rgbds_pkg::SQR_W-1:0]   radicand,
  output logic                          busy,
  output logic                          done,
  output logic [rgbds_pkg::DIFF_W-1:0]  root
);
  import rgbds_pkg::*;

  localparam int CNT_W = $clog2(DIFF_W + 1);

  logic [SQR_W-1:0]  rad_r;
  logic [DIFF_W:0]   rem_r;
  logic [DIFF_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;

  logic [DIFF_W+2:0] rem_sh;
  logic [DIFF_W+2:0] trial;
  logic              fits;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_r, rad_r[SQR_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(DIFF_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cnt_r != '0) begin
      rad_r  <= {rad_r[SQR_W-3:0], 2'b00};
      rem_r  <= fits ? (DIFF_W+1)'(rem_sh - trial) : (DIFF_W+1)'(rem_sh);
      root_r <= {root_r[DIFF_W-2:0], fits};
    end
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign root = root_r;

endmodule
